// File: design/pmd_pkg.sv
// Package with shared types and constants for the PID motor drive unit.
package pmd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OpW = 18;
  localparam int unsigned AccW = 36;

  localparam logic [CfgIdxW-1:0] RegPropGain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFilterAlpha = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFilterEnable = 3'd4;
  localparam logic [CfgIdxW-1:0] RegUpperLimit = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLowerLimit = 3'd6;
  localparam logic [CfgIdxW-1:0] RegProtectEnable = 3'd7;

  localparam logic signed [17:0] IntegClamp = 18'sd1600;
  localparam logic signed [16:0] DeadBand = 17'sd64;
  localparam logic [23:0] DriveMax = 24'd254;
  localparam logic [AccW-1:0] RoundHalfOut = 36'd2048;
  localparam logic signed [AccW-1:0] RoundHalfFilt = 36'sd32768;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

endpackage

// File: design/pmd_mac.sv
// Shared signed multiplier with a registered product and an accumulator.
module pmd_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pmd_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [pmd_pkg::OpW-1:0]       op_a_i,
  input  logic signed [pmd_pkg::OpW-1:0]       op_b_i,
  output logic signed [pmd_pkg::AccW-1:0]      acc_o
);

  logic signed [pmd_pkg::AccW-1:0] prod_q;
  logic signed [pmd_pkg::AccW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc_load) begin
      acc_q <= prod_q;
    end else if (ctl_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: design/pid_motor_drive_unit.sv
// PID motor drive unit: filter, PID sum on a shared multiplier, clamp and drive output.
// One word is taken at a time; the input is not ready until the result is registered.
// With the filter off a word runs StErr through StRound; with the filter on it first passes
// StFiltA to StFiltR, and a result left waiting at the output holds the sequencer in StRound.
// The sequencer steps one multiply-accumulate per cycle through a single 18 by 18 multiplier.
// The asynchronous active-low reset clears the registers, integral, previous error and filter state.
module pid_motor_drive_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // measurement[15:0], setpoint[31:16]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // drive[8:0], dir_high[9], duty[17:10]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pmd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pmd_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StFiltA = 4'd1;
  localparam logic [3:0] StFiltB = 4'd2;
  localparam logic [3:0] StFiltC = 4'd3;
  localparam logic [3:0] StFiltR = 4'd4;
  localparam logic [3:0] StErr = 4'd5;
  localparam logic [3:0] StDiff = 4'd6;
  localparam logic [3:0] StMulP = 4'd7;
  localparam logic [3:0] StMulD = 4'd8;
  localparam logic [3:0] StMulI = 4'd9;
  localparam logic [3:0] StSum = 4'd10;
  localparam logic [3:0] StAbs = 4'd11;
  localparam logic [3:0] StRound = 4'd12;

  logic [3:0] state_q, state_d;

  logic signed [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [15:0]        filter_alpha_q;
  logic               filter_enable_q, protect_enable_q;
  logic signed [15:0] upper_limit_q, lower_limit_q;

  logic signed [15:0] meas_q, setp_q, y_q, filt_prev_q;
  logic signed [16:0] err_q, prev_err_q;
  logic signed [17:0] derr_q;
  logic signed [11:0] integ_q, isum_q;
  logic               dir_q;
  logic [pmd_pkg::AccW-1:0] mag_q;
  logic               neg_q;

  logic               out_valid_q;
  logic signed [8:0]  out_drive_q;
  logic               out_dir_q;
  logic [7:0]         out_duty_q;

  pmd_pkg::mac_ctl_t                 mac_ctl;
  logic signed [pmd_pkg::OpW-1:0]    op_a, op_b;
  logic signed [pmd_pkg::AccW-1:0]   acc;

  logic               accept;
  logic               out_free;
  logic signed [pmd_pkg::AccW-1:0] filt_rnd;
  logic signed [17:0] isum_raw;
  logic signed [11:0] isum_clamped;
  logic [pmd_pkg::AccW-1:0] mag_rnd;
  logic [23:0]        mag_int;
  logic [7:0]         duty;
  logic signed [8:0]  drive;
  logic               zero_drive;

  pmd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q      <= '0;
      integ_gain_q     <= '0;
      deriv_gain_q     <= '0;
      filter_alpha_q   <= '0;
      filter_enable_q  <= 1'b0;
      upper_limit_q    <= '0;
      lower_limit_q    <= '0;
      protect_enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pmd_pkg::RegPropGain:      prop_gain_q      <= cfg_data_i;
        pmd_pkg::RegIntegGain:     integ_gain_q     <= cfg_data_i;
        pmd_pkg::RegDerivGain:     deriv_gain_q     <= cfg_data_i;
        pmd_pkg::RegFilterAlpha:   filter_alpha_q   <= cfg_data_i;
        pmd_pkg::RegFilterEnable:  filter_enable_q  <= cfg_data_i[0];
        pmd_pkg::RegUpperLimit:    upper_limit_q    <= cfg_data_i;
        pmd_pkg::RegLowerLimit:    lower_limit_q    <= cfg_data_i;
        pmd_pkg::RegProtectEnable: protect_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    unique case (state_q)
      StFiltA: begin
        mac_ctl.mul_en = 1'b1;
        op_a = {2'b00, filter_alpha_q};
        op_b = {{2{filt_prev_q[15]}}, filt_prev_q};
      end
      StFiltB: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        op_a = 18'sh10000 - {2'b00, filter_alpha_q};
        op_b = {{2{meas_q[15]}}, meas_q};
      end
      StFiltC: mac_ctl.acc_add = 1'b1;
      StMulP: begin
        mac_ctl.mul_en = 1'b1;
        op_a = {{2{prop_gain_q[15]}}, prop_gain_q};
        op_b = {err_q[16], err_q};
      end
      StMulD: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        op_a = {{2{deriv_gain_q[15]}}, deriv_gain_q};
        op_b = derr_q;
      end
      StMulI: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_add = 1'b1;
        op_a = {{2{integ_gain_q[15]}}, integ_gain_q};
        op_b = {{6{isum_q[11]}}, isum_q};
      end
      StSum: mac_ctl.acc_add = 1'b1;
      default: ;
    endcase
  end

  assign filt_rnd = acc + pmd_pkg::RoundHalfFilt;
  assign isum_raw = {{6{integ_q[11]}}, integ_q} + {err_q[16], err_q};

  always_comb begin
    if (isum_raw > pmd_pkg::IntegClamp) begin
      isum_clamped = 12'(pmd_pkg::IntegClamp);
    end else if (isum_raw < -pmd_pkg::IntegClamp) begin
      isum_clamped = 12'(-pmd_pkg::IntegClamp);
    end else begin
      isum_clamped = isum_raw[11:0];
    end
  end

  assign mag_rnd = mag_q + pmd_pkg::RoundHalfOut;
  assign mag_int = mag_rnd[35:12];
  assign duty = (mag_int > pmd_pkg::DriveMax) ? 8'(pmd_pkg::DriveMax) : mag_int[7:0];
  assign zero_drive = (protect_enable_q && (upper_limit_q <= y_q || lower_limit_q >= y_q))
                    || (err_q <= pmd_pkg::DeadBand && err_q >= -pmd_pkg::DeadBand);
  assign drive = zero_drive ? 9'sd0 : (neg_q ? -$signed({1'b0, duty}) : $signed({1'b0, duty}));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = filter_enable_q ? StFiltA : StErr;
      StFiltA: state_d = StFiltB;
      StFiltB: state_d = StFiltC;
      StFiltC: state_d = StFiltR;
      StFiltR: state_d = StErr;
      StErr:   state_d = StDiff;
      StDiff:  state_d = StMulP;
      StMulP:  state_d = StMulD;
      StMulD:  state_d = StMulI;
      StMulI:  state_d = StSum;
      StSum:   state_d = StAbs;
      StAbs:   state_d = StRound;
      StRound: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      filt_prev_q <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StRound && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StFiltR) begin
        filt_prev_q <= filt_rnd[31:16];
      end
      if (state_q == StDiff) begin
        prev_err_q <= err_q;
      end
      if (state_q == StRound && out_free) begin
        integ_q <= zero_drive ? 12'sd0 : isum_q;
        if (drive > 9'sd0) begin
          dir_q <= 1'b1;
        end else if (drive < 9'sd0) begin
          dir_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= s_axis_tdata[15:0];
      setp_q <= s_axis_tdata[31:16];
      y_q    <= s_axis_tdata[15:0];
    end
    if (state_q == StFiltR) begin
      y_q <= filt_rnd[31:16];
    end
    if (state_q == StErr) begin
      err_q <= {y_q[15], y_q} - {setp_q[15], setp_q};
    end
    if (state_q == StDiff) begin
      derr_q <= {err_q[16], err_q} - {prev_err_q[16], prev_err_q};
      isum_q <= isum_clamped;
    end
    if (state_q == StAbs) begin
      neg_q <= acc[pmd_pkg::AccW-1];
      mag_q <= acc[pmd_pkg::AccW-1] ? 36'(-acc) : 36'(acc);
    end
    if (state_q == StRound && out_free) begin
      out_drive_q <= drive;
      out_duty_q  <= zero_drive ? 8'd0 : duty;
      if (drive > 9'sd0) begin
        out_dir_q <= 1'b1;
      end else if (drive < 9'sd0) begin
        out_dir_q <= 1'b0;
      end else begin
        out_dir_q <= dir_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_duty_q, out_dir_q, out_drive_q};

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == StIdle)
    else $error("input ready outside the idle state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != StIdle)
    else $error("sequencer stayed idle after taking a word");

  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q <= 12'sd1600 && integ_q >= -12'sd1600)
    else $error("integral outside its clamp");

  a_duty_matches_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_drive_q == 9'sd0) == (out_duty_q == 8'd0)))
    else $error("duty and drive disagree on zero");

  a_dir_follows_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drive_q != 9'sd0) |-> (out_dir_q == !out_drive_q[8]))
    else $error("direction level does not follow the drive sign");

endmodule
